// ===== hw/rtl/lbm_pkg.sv =====
package lbm_pkg;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE = 32'sd16777216;
  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;

  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = 10;
  localparam int SQ_LAT    = 2;
  localparam int LANE_LAT  = 8;
  localparam int SIDE_DLY  = DIV_LAT + SQ_LAT;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + SQ_LAT + LANE_LAT;
  localparam int NUM_DIR   = 9;

  localparam logic [3:0] DIR_REST = 4'd0;
  localparam logic [3:0] DIR_E    = 4'd1;
  localparam logic [3:0] DIR_N    = 4'd2;
  localparam logic [3:0] DIR_W    = 4'd3;
  localparam logic [3:0] DIR_S    = 4'd4;
  localparam logic [3:0] DIR_NE   = 4'd5;
  localparam logic [3:0] DIR_NW   = 4'd6;
  localparam logic [3:0] DIR_SW   = 4'd7;
  localparam logic [3:0] DIR_SE   = 4'd8;

  localparam logic [1:0] CFG_RELAX_RATE = 2'd0;
  localparam logic [1:0] CFG_FORCE_BASE = 2'd1;
  localparam logic [1:0] CFG_MAP_GAIN   = 2'd2;

  localparam q_t W_REST = 32'sd7456540;
  localparam q_t W_AXIS = 32'sd1864135;
  localparam q_t W_DIAG = 32'sd466034;

  typedef struct packed {
    logic [7:0]       x0;
    logic [7:0]       y0;
    logic [8:0][31:0] pop;
    q_t               rho;
    q_t               beta;
  } side_t;

  typedef struct packed {
    logic [7:0] x0;
    logic [7:0] y0;
    q_t         rho;
    q_t         ux;
    q_t         uy;
  } meta_t;

  typedef struct packed {
    q_t omega;
    q_t omega1;
    q_t coeff;
  } relax_t;

  function automatic q_t sat32(input logic signed [65:0] v);
    if (v > 66'(Q_MAX)) begin
      return Q_MAX;
    end
    if (v < 66'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(v[31:0]);
  endfunction

  // product rounded to nearest, ties up, then saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] m;
    logic signed [65:0] p;
    m = a * b;
    p = 66'(m) + 66'sd8388608;
    return sat32(p >>> 24);
  endfunction

  function automatic logic signed [1:0] dir_cx(input logic [3:0] k);
    case (k)
      DIR_E, DIR_NE, DIR_SE: return 2'sd1;
      DIR_W, DIR_NW, DIR_SW: return -2'sd1;
      default:               return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_cy(input logic [3:0] k);
    case (k)
      DIR_N, DIR_NE, DIR_NW: return 2'sd1;
      DIR_S, DIR_SW, DIR_SE: return -2'sd1;
      default:               return 2'sd0;
    endcase
  endfunction

  function automatic q_t dir_w(input logic [3:0] k);
    case (k)
      DIR_REST:                     return W_REST;
      DIR_E, DIR_N, DIR_W, DIR_S:   return W_AXIS;
      default:                      return W_DIAG;
    endcase
  endfunction

  function automatic logic signed [65:0] cmul(input logic signed [1:0] c, input q_t v);
    if (c == 2'sd1) begin
      return 66'(v);
    end
    if (c == -2'sd1) begin
      return -66'(v);
    end
    return '0;
  endfunction

endpackage

// ===== hw/rtl/lbm_if.sv =====
interface lbm_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         cell_x;
  logic [7:0]         cell_y;
  logic signed [31:0] pop_rest;
  logic signed [31:0] pop_east;
  logic signed [31:0] pop_north;
  logic signed [31:0] pop_west;
  logic signed [31:0] pop_south;
  logic signed [31:0] pop_northeast;
  logic signed [31:0] pop_northwest;
  logic signed [31:0] pop_southwest;
  logic signed [31:0] pop_southeast;
  logic signed [31:0] force_map;

  modport source (
    output valid, cell_x, cell_y, pop_rest, pop_east, pop_north, pop_west, pop_south,
           pop_northeast, pop_northwest, pop_southwest, pop_southeast, force_map,
    input  ready
  );
  modport sink (
    input  valid, cell_x, cell_y, pop_rest, pop_east, pop_north, pop_west, pop_south,
           pop_northeast, pop_northwest, pop_southwest, pop_southeast, force_map,
    output ready
  );
endinterface

interface lbm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         direction;
  logic [7:0]         dest_x;
  logic [7:0]         dest_y;
  logic signed [31:0] new_population;
  logic signed [31:0] density;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic               last;

  modport source (
    output valid, direction, dest_x, dest_y, new_population, density, velocity_x,
           velocity_y, last,
    input  ready
  );
  modport sink (
    input  valid, direction, dest_x, dest_y, new_population, density, velocity_x,
           velocity_y, last,
    output ready
  );
endinterface

// ===== hw/rtl/lbm_front.sv =====
module lbm_front #(
  parameter int GRID_X = lbm_pkg::GRID_X_DEF,
  parameter int GRID_Y = lbm_pkg::GRID_Y_DEF
) (
  input  logic           clk_i,
  input  logic           adv_i,
  input  lbm_pkg::q_t    fbase_i,
  input  logic [24:0]    mgain_i,
  lbm_in_if.sink         cell_ch,
  output lbm_pkg::side_t side_o,
  output lbm_pkg::q_t    num_x_o,
  output lbm_pkg::q_t    num_y_o
);

  logic [7:0] xmod [256];
  logic [7:0] ymod [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign xmod[i] = 8'(i % GRID_X);
    assign ymod[i] = 8'(i % GRID_Y);
  end

  logic [8:0][31:0]   pop_in;
  logic signed [35:0] s_rho, s_mx, s_my;

  lbm_pkg::side_t sd1_q, sd2_q, sd3_q, sd4_q;
  lbm_pkg::q_t    mx1_q, my1_q, gf1_q;
  lbm_pkg::q_t    mx2_q, my2_q, sc2_q;
  lbm_pkg::q_t    mx3_q, my3_q;
  lbm_pkg::q_t    nx4_q, ny4_q;

  assign cell_ch.ready = adv_i;

  assign pop_in = {cell_ch.pop_southeast, cell_ch.pop_southwest, cell_ch.pop_northwest,
                   cell_ch.pop_northeast, cell_ch.pop_south, cell_ch.pop_west,
                   cell_ch.pop_north, cell_ch.pop_east, cell_ch.pop_rest};

  always_comb begin
    s_rho = '0;
    s_mx  = '0;
    s_my  = '0;
    for (int k = 0; k < lbm_pkg::NUM_DIR; k++) begin
      s_rho = s_rho + 36'($signed(pop_in[k]));
      s_mx  = s_mx + 36'(lbm_pkg::cmul(lbm_pkg::dir_cx(4'(k)), $signed(pop_in[k])));
      s_my  = s_my + 36'(lbm_pkg::cmul(lbm_pkg::dir_cy(4'(k)), $signed(pop_in[k])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sd1_q <= '{x0:   xmod[cell_ch.cell_x],
                 y0:   ymod[cell_ch.cell_y],
                 pop:  pop_in,
                 rho:  lbm_pkg::sat32(66'(s_rho)),
                 beta: '0};
      mx1_q <= lbm_pkg::sat32(66'(s_mx));
      my1_q <= lbm_pkg::sat32(66'(s_my));
      gf1_q <= lbm_pkg::qmul($signed(32'(mgain_i)), cell_ch.force_map);

      sd2_q <= sd1_q;
      mx2_q <= mx1_q;
      my2_q <= my1_q;
      sc2_q <= lbm_pkg::sat32(66'(gf1_q) + 66'(lbm_pkg::Q_ONE));

      sd3_q <= '{x0:   sd2_q.x0,
                 y0:   sd2_q.y0,
                 pop:  sd2_q.pop,
                 rho:  sd2_q.rho,
                 beta: lbm_pkg::qmul(fbase_i, sc2_q)};
      mx3_q <= mx2_q;
      my3_q <= my2_q;

      // beta * 0.5 rounds to (beta + 1) >> 1
      sd4_q <= sd3_q;
      nx4_q <= lbm_pkg::sat32(66'(mx3_q) + ((66'(sd3_q.beta) + 66'sd1) >>> 1));
      ny4_q <= my3_q;
    end
  end

  assign side_o  = sd4_q;
  assign num_x_o = nx4_q;
  assign num_y_o = ny4_q;

endmodule

// ===== hw/rtl/lbm_div.sv =====
module lbm_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  lbm_pkg::q_t num_i,
  input  lbm_pkg::q_t den_i,
  output lbm_pkg::q_t quo_o
);

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] d;
    logic [31:0] b;
    logic [31:0] q;
    logic        neg;
    logic        fix;
    logic [31:0] fval;
  } dst_t;

  function automatic dst_t div_step(input dst_t s);
    dst_t        t;
    logic [31:0] sh;
    t = s;
    for (int j = 0; j < 4; j++) begin
      sh  = {t.r[30:0], t.b[31]};
      t.b = {t.b[30:0], 1'b0};
      if (sh >= t.d) begin
        t.r = sh - t.d;
        t.q = {t.q[30:0], 1'b1};
      end else begin
        t.r = sh;
        t.q = {t.q[30:0], 1'b0};
      end
    end
    return t;
  endfunction

  logic [32:0] mag;
  logic [31:0] a;
  logic        neg, denpos, ovf;
  dst_t        pre;
  dst_t        st_q [9];
  lbm_pkg::q_t res_q;

  always_comb begin
    neg    = num_i[31];
    mag    = neg ? (33'd0 - 33'(num_i)) : 33'(num_i);
    a      = mag[31:0];
    denpos = !den_i[31] && (den_i != '0);
    ovf    = {7'd0, a} >= {den_i, 7'd0};
    pre.r  = {8'd0, a[31:8]};
    pre.d  = den_i;
    pre.b  = {a[7:0], 24'd0};
    pre.q  = '0;
    pre.neg = neg;
    pre.fix = !denpos || ovf;
    if (!denpos) begin
      if (num_i > 0) begin
        pre.fval = lbm_pkg::Q_MAX;
      end else if (num_i < 0) begin
        pre.fval = lbm_pkg::Q_MIN;
      end else begin
        pre.fval = '0;
      end
    end else begin
      pre.fval = neg ? lbm_pkg::Q_MIN : lbm_pkg::Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre;
      for (int i = 1; i < 9; i++) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
      if (st_q[8].fix) begin
        res_q <= st_q[8].fval;
      end else if (st_q[8].neg) begin
        res_q <= lbm_pkg::q_t'(32'd0 - st_q[8].q);
      end else begin
        res_q <= lbm_pkg::q_t'(st_q[8].q);
      end
    end
  end

  assign quo_o = res_q;

endmodule

// ===== hw/rtl/lbm_lane.sv =====
module lbm_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic signed [1:0] cx_i,
  input  logic signed [1:0] cy_i,
  input  lbm_pkg::q_t       w_i,
  input  lbm_pkg::relax_t   rlx_i,
  input  lbm_pkg::q_t       ux_i,
  input  lbm_pkg::q_t       uy_i,
  input  lbm_pkg::q_t       u2_i,
  input  lbm_pkg::q_t       rho_i,
  input  lbm_pkg::q_t       beta_i,
  input  lbm_pkg::q_t       pop_i,
  output lbm_pkg::q_t       np_o
);

  lbm_pkg::q_t eu1_q, ux1_q, u21_q, rho1_q, beta1_q, pop1_q;
  lbm_pkg::q_t ee2_q, br2_q, eu2_q, u22_q, rho2_q, beta2_q, pop2_q;
  lbm_pkg::q_t eueu3_q, bb3_q, eu3_q, u23_q, rho3_q, pop3_q;
  lbm_pkg::q_t poly4_q, cb4_q, rho4_q, pop4_q;
  lbm_pkg::q_t rp5_q, frc5_q, pop5_q;
  lbm_pkg::q_t feq6_q, pp6_q, frc6_q;
  lbm_pkg::q_t fo7_q, pp7_q, frc7_q;
  lbm_pkg::q_t np8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eu1_q   <= lbm_pkg::sat32(lbm_pkg::cmul(cx_i, ux_i) + lbm_pkg::cmul(cy_i, uy_i));
      ux1_q   <= ux_i;
      u21_q   <= u2_i;
      rho1_q  <= rho_i;
      beta1_q <= beta_i;
      pop1_q  <= pop_i;

      ee2_q   <= lbm_pkg::qmul(eu1_q, eu1_q);
      br2_q   <= lbm_pkg::sat32(3 * (lbm_pkg::cmul(cx_i, lbm_pkg::Q_ONE) - 66'(ux1_q))
                                + 9 * lbm_pkg::cmul(cx_i, eu1_q));
      eu2_q   <= eu1_q;
      u22_q   <= u21_q;
      rho2_q  <= rho1_q;
      beta2_q <= beta1_q;
      pop2_q  <= pop1_q;

      // 4.5 * ee rounds to (9 * ee + 1) >> 1
      eueu3_q <= lbm_pkg::sat32((9 * 66'(ee2_q) + 66'sd1) >>> 1);
      bb3_q   <= lbm_pkg::qmul(beta2_q, br2_q);
      eu3_q   <= eu2_q;
      u23_q   <= u22_q;
      rho3_q  <= rho2_q;
      pop3_q  <= pop2_q;

      poly4_q <= lbm_pkg::sat32(66'(lbm_pkg::Q_ONE) + 3 * 66'(eu3_q) + 66'(eueu3_q)
                                + 66'(u23_q));
      cb4_q   <= lbm_pkg::qmul(rlx_i.coeff, bb3_q);
      rho4_q  <= rho3_q;
      pop4_q  <= pop3_q;

      rp5_q   <= lbm_pkg::qmul(rho4_q, poly4_q);
      frc5_q  <= lbm_pkg::qmul(w_i, cb4_q);
      pop5_q  <= pop4_q;

      feq6_q  <= lbm_pkg::qmul(w_i, rp5_q);
      pp6_q   <= lbm_pkg::qmul(pop5_q, rlx_i.omega1);
      frc6_q  <= frc5_q;

      fo7_q   <= lbm_pkg::qmul(feq6_q, rlx_i.omega);
      pp7_q   <= pp6_q;
      frc7_q  <= frc6_q;

      np8_q   <= lbm_pkg::sat32(66'(pp7_q) + 66'(fo7_q) + 66'(frc7_q));
    end
  end

  assign np_o = np8_q;

endmodule

// ===== hw/rtl/lbm_merge.sv =====
module lbm_merge #(
  parameter int GRID_X = lbm_pkg::GRID_X_DEF,
  parameter int GRID_Y = lbm_pkg::GRID_Y_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_i,
  input  logic [8:0][31:0] np_i,
  input  lbm_pkg::meta_t   meta_i,
  output logic             rdy_o,
  lbm_out_if.source        res_ch
);

  logic [8:0][31:0]  np_q;
  lbm_pkg::meta_t    meta_q;
  logic              busy_q;
  logic [3:0]        cnt_q;
  logic              fire, done;
  logic signed [1:0] cx, cy;

  assign fire  = busy_q && res_ch.ready;
  assign done  = fire && (cnt_q == lbm_pkg::DIR_SE);
  assign rdy_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= lbm_pkg::DIR_REST;
    end else if (ld_i) begin
      busy_q <= 1'b1;
      cnt_q  <= lbm_pkg::DIR_REST;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      np_q   <= np_i;
      meta_q <= meta_i;
    end
  end

  always_comb begin
    cx = lbm_pkg::dir_cx(cnt_q);
    cy = lbm_pkg::dir_cy(cnt_q);
    if (cx == 2'sd1) begin
      res_ch.dest_x = (32'(meta_q.x0) == 32'(GRID_X - 1)) ? 8'd0 : meta_q.x0 + 8'd1;
    end else if (cx == -2'sd1) begin
      res_ch.dest_x = (meta_q.x0 == 8'd0) ? 8'(GRID_X - 1) : meta_q.x0 - 8'd1;
    end else begin
      res_ch.dest_x = meta_q.x0;
    end
    if (cy == 2'sd1) begin
      res_ch.dest_y = (32'(meta_q.y0) == 32'(GRID_Y - 1)) ? 8'd0 : meta_q.y0 + 8'd1;
    end else if (cy == -2'sd1) begin
      res_ch.dest_y = (meta_q.y0 == 8'd0) ? 8'(GRID_Y - 1) : meta_q.y0 - 8'd1;
    end else begin
      res_ch.dest_y = meta_q.y0;
    end
  end

  assign res_ch.valid          = busy_q;
  assign res_ch.direction      = cnt_q;
  assign res_ch.new_population = $signed(np_q[cnt_q]);
  assign res_ch.density        = meta_q.rho;
  assign res_ch.velocity_x     = meta_q.ux;
  assign res_ch.velocity_y     = meta_q.uy;
  assign res_ch.last           = (cnt_q == lbm_pkg::DIR_SE);

endmodule

// ===== hw/rtl/lattice_boltzmann_d2q9_cell_update.sv =====
// Channel   Dir  Handshake      Payload
// cell_ch   in   valid/ready    position, nine populations, force map value
// res_ch    out  valid/ready    direction, destination, population, rho, ux, uy, last
// cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_data_i
//
// The result port emits nine transactions per cell; the pipeline keeps accepting cells
// while the merge buffer emits them, until its last stage holds a cell not yet taken.
// The nine direction lanes and two pipelined dividers (4 quotient bits per stage) run
// in one lockstep pipeline; it stalls only when its last stage waits on the merge buffer.
// Reset clears pipeline valids, the merge buffer and loads register defaults.
module lattice_boltzmann_d2q9_cell_update #(
  parameter int GRID_X = lbm_pkg::GRID_X_DEF,
  parameter int GRID_Y = lbm_pkg::GRID_Y_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbm_in_if.sink      cell_ch,
  lbm_out_if.source   res_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int PL = lbm_pkg::PIPE_LAT;

  logic [25:0]       relax_q;
  lbm_pkg::q_t       fbase_q;
  logic [24:0]       mgain_q;
  lbm_pkg::relax_t   rlx;
  lbm_pkg::q_t       omega;

  logic [PL-1:0]     vld_q;
  logic              adv, mrg_rdy, ld;

  lbm_pkg::side_t    side_f;
  lbm_pkg::q_t       num_x, num_y, ux_d, uy_d;
  lbm_pkg::side_t    sda_q [lbm_pkg::SIDE_DLY];
  lbm_pkg::meta_t    mda_q [lbm_pkg::LANE_LAT];
  lbm_pkg::side_t    sd_l;

  lbm_pkg::q_t       sqx_q, sqy_q, ux1_q, uy1_q, ux2_q, uy2_q, u2_q;
  lbm_pkg::q_t       usq, hx;
  logic [8:0][31:0]  np_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= 26'd16777216;
      fbase_q <= '0;
      mgain_q <= 25'd1677722;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbm_pkg::CFG_RELAX_RATE: relax_q <= cfg_data_i[25:0];
        lbm_pkg::CFG_FORCE_BASE: fbase_q <= $signed(cfg_data_i);
        lbm_pkg::CFG_MAP_GAIN:   mgain_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  // omega/2 rounds to (omega + 1) >> 1
  assign omega      = $signed(32'(relax_q));
  assign rlx.omega  = omega;
  assign rlx.omega1 = lbm_pkg::sat32(66'(lbm_pkg::Q_ONE) - 66'(omega));
  assign rlx.coeff  = lbm_pkg::sat32(66'(lbm_pkg::Q_ONE) - ((66'(omega) + 66'sd1) >>> 1));

  assign adv = !vld_q[PL-1] || mrg_rdy;
  assign ld  = vld_q[PL-1] && mrg_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PL-2:0], cell_ch.valid};
    end
  end

  lbm_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_front (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .fbase_i (fbase_q),
    .mgain_i (mgain_q),
    .cell_ch (cell_ch),
    .side_o  (side_f),
    .num_x_o (num_x),
    .num_y_o (num_y)
  );

  lbm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_x),
    .den_i (side_f.rho),
    .quo_o (ux_d)
  );

  lbm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_y),
    .den_i (side_f.rho),
    .quo_o (uy_d)
  );

  always_comb begin
    usq = lbm_pkg::sat32(66'(sqx_q) + 66'(sqy_q));
    hx  = lbm_pkg::sat32((3 * 66'(usq) + 66'sd1) >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sda_q[0] <= side_f;
      for (int i = 1; i < lbm_pkg::SIDE_DLY; i++) begin
        sda_q[i] <= sda_q[i-1];
      end
      sqx_q <= lbm_pkg::qmul(ux_d, ux_d);
      sqy_q <= lbm_pkg::qmul(uy_d, uy_d);
      ux1_q <= ux_d;
      uy1_q <= uy_d;
      u2_q  <= lbm_pkg::sat32(-66'(hx));
      ux2_q <= ux1_q;
      uy2_q <= uy1_q;
      mda_q[0] <= '{x0: sd_l.x0, y0: sd_l.y0, rho: sd_l.rho, ux: ux2_q, uy: uy2_q};
      for (int i = 1; i < lbm_pkg::LANE_LAT; i++) begin
        mda_q[i] <= mda_q[i-1];
      end
    end
  end

  assign sd_l = sda_q[lbm_pkg::SIDE_DLY-1];

  for (genvar k = 0; k < lbm_pkg::NUM_DIR; k++) begin : g_lane
    lbm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cx_i   (lbm_pkg::dir_cx(4'(k))),
      .cy_i   (lbm_pkg::dir_cy(4'(k))),
      .w_i    (lbm_pkg::dir_w(4'(k))),
      .rlx_i  (rlx),
      .ux_i   (ux2_q),
      .uy_i   (uy2_q),
      .u2_i   (u2_q),
      .rho_i  (sd_l.rho),
      .beta_i (sd_l.beta),
      .pop_i  ($signed(sd_l.pop[k])),
      .np_o   (np_all[k])
    );
  end

  lbm_merge #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld),
    .np_i   (np_all),
    .meta_i (mda_q[lbm_pkg::LANE_LAT-1]),
    .rdy_o  (mrg_rdy),
    .res_ch (res_ch)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PL-1] && !adv |=> vld_q[PL-1])
    else $error("stalled cell left the last stage");

  a_in_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ch.valid && cell_ch.ready |=> vld_q[0])
    else $error("accepted transaction not tracked");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> res_ch.valid && res_ch.direction == lbm_pkg::DIR_REST)
    else $error("loaded cell does not start at rest direction");

  a_cell_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && res_ch.ready && res_ch.last
      |=> !res_ch.valid || res_ch.direction == lbm_pkg::DIR_REST)
    else $error("result sequence did not restart");

endmodule

// ===== test/lbm_cell_checker.sv =====
`timescale 1ns / 100ps

module lbm_cell_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbm_in_if           cell_ch,
  lbm_out_if          res_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint HALF = 64'sd8388608;
  localparam longint ONE  = 64'sd16777216;

  typedef struct {
    logic [3:0]  dir;
    logic [7:0]  dx;
    logic [7:0]  dy;
    lbm_pkg::q_t pop;
    lbm_pkg::q_t rho;
    lbm_pkg::q_t ux;
    lbm_pkg::q_t uy;
    logic        last;
  } lane_res_t;

  lane_res_t expected_lanes[$];

  const int     cx_tab[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  const int     cy_tab[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  const longint w_tab[9]  = '{7456540, 1864135, 1864135, 1864135, 1864135,
                              466034, 466034, 466034, 466034};

  logic [25:0] omega_r;
  lbm_pkg::q_t force_r;
  logic [24:0] gain_r;
  int          fails;

  assign fail_count_o = fails;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qm(longint a, longint b);
    longint p;
    p = a * b + HALF;
    return sat(p >>> 24);
  endfunction

  function automatic longint qd(longint num, longint den);
    if (den <= 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return sat((num * ONE) / den);
  endfunction

  task automatic predict_cell();
    longint pop[9];
    longint rho, mx, my, scale, beta, ux, uy, om, om1, coeff, usq, u2;
    longint eu, eueu, poly, feq, br, frc, np;
    lane_res_t r;
    pop[0] = longint'(cell_ch.pop_rest);
    pop[1] = longint'(cell_ch.pop_east);
    pop[2] = longint'(cell_ch.pop_north);
    pop[3] = longint'(cell_ch.pop_west);
    pop[4] = longint'(cell_ch.pop_south);
    pop[5] = longint'(cell_ch.pop_northeast);
    pop[6] = longint'(cell_ch.pop_northwest);
    pop[7] = longint'(cell_ch.pop_southwest);
    pop[8] = longint'(cell_ch.pop_southeast);
    rho = 0;
    mx = 0;
    my = 0;
    for (int k = 0; k < 9; k++) begin
      rho += pop[k];
      mx += cx_tab[k] * pop[k];
      my += cy_tab[k] * pop[k];
    end
    rho = sat(rho);
    mx = sat(mx);
    my = sat(my);
    scale = sat(ONE + qm(longint'(gain_r), longint'(cell_ch.force_map)));
    beta = qm(longint'(force_r), scale);
    ux = qd(sat(mx + qm(beta, HALF)), rho);
    uy = qd(my, rho);
    om = longint'(omega_r);
    om1 = sat(ONE - om);
    coeff = sat(ONE - qm(HALF, om));
    usq = sat(qm(ux, ux) + qm(uy, uy));
    u2 = sat(-qm(64'sd25165824, usq));
    for (int k = 0; k < 9; k++) begin
      eu = sat(cx_tab[k] * ux + cy_tab[k] * uy);
      eueu = qm(64'sd75497472, qm(eu, eu));
      poly = sat(ONE + 3 * eu + eueu + u2);
      feq = qm(w_tab[k], qm(rho, poly));
      br = sat(3 * (cx_tab[k] * ONE - ux) + 9 * cx_tab[k] * eu);
      frc = qm(w_tab[k], qm(coeff, qm(beta, br)));
      np = sat(qm(pop[k], om1) + qm(feq, om) + frc);
      r.dir = 4'(k);
      r.dx = 8'(int'(cell_ch.cell_x) + cx_tab[k]);
      r.dy = 8'(int'(cell_ch.cell_y) + cy_tab[k]);
      r.pop = lbm_pkg::q_t'(np);
      r.rho = lbm_pkg::q_t'(rho);
      r.ux = lbm_pkg::q_t'(ux);
      r.uy = lbm_pkg::q_t'(uy);
      r.last = (k == 8);
      expected_lanes.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_r <= 26'd16777216;
      force_r <= '0;
      gain_r  <= 25'd1677722;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbm_pkg::CFG_RELAX_RATE: omega_r <= cfg_data_i[25:0];
        lbm_pkg::CFG_FORCE_BASE: force_r <= lbm_pkg::q_t'(cfg_data_i);
        lbm_pkg::CFG_MAP_GAIN:   gain_r  <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  initial begin
    fails = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    lane_res_t e;
    if (rst_ni) begin
      if (cell_ch.valid && cell_ch.ready) begin
        predict_cell();
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_lanes.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result transaction dir %0d", res_ch.direction);
        end else begin
          e = expected_lanes.pop_front();
          if (res_ch.direction !== e.dir || res_ch.dest_x !== e.dx || res_ch.dest_y !== e.dy ||
              res_ch.new_population !== e.pop || res_ch.density !== e.rho ||
              res_ch.velocity_x !== e.ux || res_ch.velocity_y !== e.uy ||
              res_ch.last !== e.last) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch exp dir %0d dst %0d,%0d pop %h rho %h ux %h uy %h last %b",
                       e.dir, e.dx, e.dy, e.pop, e.rho, e.ux, e.uy, e.last);
              $display("         got dir %0d dst %0d,%0d pop %h rho %h ux %h uy %h last %b",
                       res_ch.direction, res_ch.dest_x, res_ch.dest_y, res_ch.new_population,
                       res_ch.density, res_ch.velocity_x, res_ch.velocity_y, res_ch.last);
            end
          end
        end
      end
      pending_o = expected_lanes.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [7:0]  x;
    logic [7:0]  y;
    lbm_pkg::q_t pop[9];
    lbm_pkg::q_t fmap;
  } cell_t;

  const int w_tab[9] = '{7456540, 1864135, 1864135, 1864135, 1864135,
                         466034, 466034, 466034, 466034};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = lbm_pkg::CFG_RELAX_RATE;
  logic [31:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          hold_req = 1'b0;

  lbm_in_if  in_ch();
  lbm_out_if out_ch();

  lattice_boltzmann_d2q9_cell_update u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cell_ch(in_ch), .res_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  lbm_cell_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cell_ch(in_ch), .res_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.pop_rest = '0;
    in_ch.pop_east = '0;
    in_ch.pop_north = '0;
    in_ch.pop_west = '0;
    in_ch.pop_south = '0;
    in_ch.pop_northeast = '0;
    in_ch.pop_northwest = '0;
    in_ch.pop_southwest = '0;
    in_ch.pop_southeast = '0;
    in_ch.force_map = '0;
  end

  // receiver: stall pattern is redrawn at random from three modes; long hold-off on request
  initial begin
    int mode;
    int cnt;
    out_ch.ready = 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (cnt == 0) begin
          mode = $urandom_range(0, 2);
          cnt = 64;
        end
        cnt--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_cell(input cell_t c);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.cell_x <= c.x;
    in_ch.cell_y <= c.y;
    in_ch.pop_rest <= c.pop[0];
    in_ch.pop_east <= c.pop[1];
    in_ch.pop_north <= c.pop[2];
    in_ch.pop_west <= c.pop[3];
    in_ch.pop_south <= c.pop[4];
    in_ch.pop_northeast <= c.pop[5];
    in_ch.pop_northwest <= c.pop[6];
    in_ch.pop_southwest <= c.pop[7];
    in_ch.pop_southeast <= c.pop[8];
    in_ch.force_map <= c.fmap;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    idle_gap(1);
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic cell_t rand_cell(input bit physical);
    cell_t c;
    c.x = 8'($urandom);
    c.y = 8'($urandom);
    for (int k = 0; k < 9; k++) begin
      if (physical) c.pop[k] = lbm_pkg::q_t'(w_tab[k] + $urandom_range(0, 600000) - 300000);
      else c.pop[k] = lbm_pkg::q_t'($urandom);
    end
    if (physical) c.fmap = lbm_pkg::q_t'($urandom_range(0, 67108864) - 33554432);
    else c.fmap = lbm_pkg::q_t'($urandom);
    return c;
  endfunction

  task automatic random_phase(input int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 20));
      end
      burst--;
      send_cell(rand_cell($urandom_range(0, 4) != 0));
    end
    drain();
  endtask

  initial begin
    cell_t c;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed cells on default registers
    c = rand_cell(1'b1);
    c.x = 8'd0;
    c.y = 8'd0;
    send_cell(c);
    c.x = 8'd255;
    c.y = 8'd255;
    send_cell(c);
    c.x = 8'd0;
    c.y = 8'd255;
    for (int k = 0; k < 9; k++) c.pop[k] = '0;
    c.fmap = '0;
    send_cell(c);
    for (int k = 0; k < 9; k++) c.pop[k] = lbm_pkg::Q_MAX;
    c.fmap = lbm_pkg::Q_MAX;
    send_cell(c);
    for (int k = 0; k < 9; k++) c.pop[k] = lbm_pkg::Q_MIN;
    c.fmap = lbm_pkg::Q_MIN;
    send_cell(c);
    for (int k = 0; k < 9; k++) c.pop[k] = '0;
    c.pop[0] = -lbm_pkg::Q_ONE;
    c.pop[1] = lbm_pkg::Q_ONE;
    c.pop[4] = lbm_pkg::Q_ONE;
    send_cell(c);
    c.pop[1] = '0;
    c.pop[3] = lbm_pkg::Q_ONE;
    c.pop[4] = '0;
    c.pop[2] = lbm_pkg::Q_ONE;
    send_cell(c);
    c.x = 8'd255;
    c.y = 8'd0;
    for (int k = 0; k < 9; k++) c.pop[k] = -1;
    c.fmap = -1;
    send_cell(c);
    send_cell(rand_cell(1'b0));
    send_cell(rand_cell(1'b0));
    drain();

    write_reg(lbm_pkg::CFG_RELAX_RATE, 32'd33554432);
    write_reg(lbm_pkg::CFG_FORCE_BASE, 32'h7fffffff);
    write_reg(lbm_pkg::CFG_MAP_GAIN, 32'd16777216);
    for (int i = 0; i < 4; i++) send_cell(rand_cell(1'b1));
    send_cell(rand_cell(1'b0));
    drain();

    write_reg(lbm_pkg::CFG_RELAX_RATE, 32'd0);
    write_reg(lbm_pkg::CFG_FORCE_BASE, 32'h80000000);
    write_reg(lbm_pkg::CFG_MAP_GAIN, 32'd0);
    for (int i = 0; i < 4; i++) send_cell(rand_cell(1'b1));
    send_cell(rand_cell(1'b0));
    drain();

    write_reg(lbm_pkg::CFG_RELAX_RATE, 32'd20000000);
    write_reg(lbm_pkg::CFG_FORCE_BASE, 32'd1000);
    write_reg(lbm_pkg::CFG_MAP_GAIN, 32'd1677722);
    hold_req = 1'b1;
    random_phase(40);

    for (int p = 0; p < 3; p++) begin
      write_reg(lbm_pkg::CFG_RELAX_RATE, $urandom_range(0, 33554432));
      write_reg(lbm_pkg::CFG_FORCE_BASE, ($urandom_range(0, 1) != 0) ? $urandom
                                                   : $urandom_range(0, 40000) - 20000);
      write_reg(lbm_pkg::CFG_MAP_GAIN, $urandom_range(0, 16777216));
      random_phase(30);
    end

    write_reg(lbm_pkg::CFG_RELAX_RATE, 32'h03ffffff);
    write_reg(lbm_pkg::CFG_FORCE_BASE, $urandom);
    write_reg(lbm_pkg::CFG_MAP_GAIN, 32'h01ffffff);
    random_phase(20);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_if.sv
hw/rtl/lbm_front.sv
hw/rtl/lbm_div.sv
hw/rtl/lbm_lane.sv
hw/rtl/lbm_merge.sv
hw/rtl/lattice_boltzmann_d2q9_cell_update.sv
test/lbm_cell_checker.sv
test/testbench.sv
